### hw/rtl/rws_pkg.sv
package rws_pkg;

  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int SAMPLE_W = 24;
  localparam int INPUT_W  = 25;
  localparam int COUNT_W  = 7;
  localparam int CFG_W    = 7;
  localparam int DEF_WINDOW_SIZE = 64;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SAMPLE_W-1:0] value;
  } cmd_t;

endpackage

### hw/rtl/rws_if.sv
interface rws_in_if;
  import rws_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [INPUT_W-1:0] sample;
  modport source (output valid, operation, sample, input ready);
  modport sink (input valid, operation, sample, output ready);
endinterface

interface rws_out_if;
  import rws_pkg::*;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic                has_data;
  logic [COUNT_W-1:0]  sample_count;
  logic [SAMPLE_W-1:0] window_min;
  logic [SAMPLE_W-1:0] window_max;
  logic [SAMPLE_W-1:0] window_mean;
  logic [SAMPLE_W-1:0] window_std_dev;
  modport source (output valid, accepted, has_data, sample_count, window_min, window_max,
                  window_mean, window_std_dev, input ready);
  modport sink (input valid, accepted, has_data, sample_count, window_min, window_max,
                window_mean, window_std_dev, output ready);
endinterface

interface rws_cfg_if;
  import rws_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_size;
  modport source (output valid, window_size, input ready);
  modport sink (input valid, window_size, output ready);
endinterface

### hw/rtl/rws_front.sv
module rws_front import rws_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic   clk,
  input  logic   rst_n,
  rws_in_if.sink in_chan,
  output logic   cmd_valid,
  input  logic   cmd_ready,
  output cmd_t   cmd
);

  localparam logic [SAMPLE_W-1:0] SMAX = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  cmd_t       q_r [2];
  cmd_t       q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push, pop;
  logic [SAMPLE_W-1:0] raw;

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push = in_chan.valid && in_chan.ready;
  assign pop  = cmd_ready && (cnt_r != 2'd0);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[0];
  assign raw = in_chan.sample[SAMPLE_W-1:0];

  always_comb begin
    cls.value = (raw > SMAX) ? SMAX : raw;
    if (in_chan.operation == OP_CLEAR) begin
      cls.kind = KIND_CLEAR;
    end else if (in_chan.sample[INPUT_W-1]) begin
      cls.kind = KIND_REJECT;
    end else begin
      cls.kind = KIND_ADD;
    end
  end

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      cnt_nxt  = cnt_nxt - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) begin
        q_nxt[0] = cls;
      end else begin
        q_nxt[1] = cls;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/rws_calc.sv
module rws_calc import rws_pkg::*; #(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int CW   = $clog2(MAX_WINDOW + 1),
  localparam int SUMW = SAMPLE_BITS + CW,
  localparam int SQW  = 2 * SAMPLE_BITS + CW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CW-1:0]          n,
  input  logic [SUMW-1:0]        sum,
  input  logic [SQW-1:0]         sumsq,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] mean,
  output logic [SAMPLE_BITS-1:0] std
);

  localparam int HW  = SAMPLE_BITS;
  localparam int QW  = 2 * SAMPLE_BITS;
  localparam int DW  = 2 * SUMW;
  localparam int DDW = 2 * CW;
  localparam int ITW = $clog2(QW + 1);
  localparam int SRW = HW + 2;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MUL  = 3'd1;
  localparam logic [2:0] C_SUB  = 3'd2;
  localparam logic [2:0] C_DIV  = 3'd3;
  localparam logic [2:0] C_SQRT = 3'd4;

  logic [2:0]     ph_r;
  logic           done_r;
  logic [CW-1:0]  n_r;
  logic [SUMW-1:0] sum_r;
  logic [SQW-1:0] sumsq_r;
  logic [DW-1:0]  ns_r, ss_r;
  logic [DDW-1:0] d_r, rem_r;
  logic [QW-1:0]  dq_r;
  logic [CW-1:0]  mrem_r;
  logic [HW-1:0]  mq_r;
  logic [ITW-1:0] it_r;
  logic [HW-1:0]  sr_r;
  logic [SRW-1:0] srem_r;

  logic [DW-1:0]  diff;
  logic [DDW:0]   t, tsub;
  logic           ge;
  logic [CW:0]    mt, mtsub;
  logic           mge;
  logic [SRW+1:0] r4, trial, r4sub;
  logic           sge;

  assign done = done_r;
  assign mean = mq_r;
  assign std  = sr_r;

  assign diff  = ns_r - ss_r;
  assign t     = {rem_r, dq_r[QW-1]};
  assign tsub  = t - {1'b0, d_r};
  assign ge    = (t >= {1'b0, d_r});
  assign mt    = {mrem_r, mq_r[HW-1]};
  assign mtsub = mt - {1'b0, n_r};
  assign mge   = (mt >= {1'b0, n_r});
  assign r4    = {srem_r, dq_r[QW-1:QW-2]};
  assign trial = (SRW+2)'({sr_r, 2'b01});
  assign r4sub = r4 - trial;
  assign sge   = (r4 >= trial);

  always_ff @(posedge clk) begin
    case (ph_r)
      C_IDLE: begin
        if (start) begin
          n_r     <= n;
          sum_r   <= sum;
          sumsq_r <= sumsq;
        end
      end
      C_MUL: begin
        ns_r <= DW'(n_r * sumsq_r);
        ss_r <= sum_r * sum_r;
        d_r  <= n_r * n_r;
      end
      C_SUB: begin
        rem_r  <= diff[DW-1:QW];
        dq_r   <= diff[QW-1:0];
        mrem_r <= sum_r[SUMW-1:HW];
        mq_r   <= sum_r[HW-1:0];
        it_r   <= '0;
      end
      C_DIV: begin
        rem_r <= ge ? tsub[DDW-1:0] : t[DDW-1:0];
        dq_r  <= {dq_r[QW-2:0], ge};
        if (it_r < ITW'(HW)) begin
          mrem_r <= mge ? mtsub[CW-1:0] : mt[CW-1:0];
          mq_r   <= {mq_r[HW-2:0], mge};
        end
        it_r <= (it_r == ITW'(QW - 1)) ? '0 : it_r + 1'b1;
        sr_r   <= '0;
        srem_r <= '0;
      end
      C_SQRT: begin
        srem_r <= sge ? r4sub[SRW-1:0] : r4[SRW-1:0];
        sr_r   <= {sr_r[HW-2:0], sge};
        dq_r   <= {dq_r[QW-3:0], 2'b00};
        it_r   <= it_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      case (ph_r)
        C_IDLE: begin
          if (start) begin
            ph_r   <= C_MUL;
            done_r <= 1'b0;
          end
        end
        C_MUL: ph_r <= C_SUB;
        C_SUB: ph_r <= C_DIV;
        C_DIV: begin
          if (it_r == ITW'(QW - 1)) begin
            ph_r <= C_SQRT;
          end
        end
        C_SQRT: begin
          if (it_r == ITW'(HW - 1)) begin
            ph_r   <= C_IDLE;
            done_r <= 1'b1;
          end
        end
        default: ph_r <= C_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/rws_back.sv
module rws_back import rws_pkg::*; #(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  rws_cfg_if.sink    cfg_chan,
  rws_out_if.source  out_chan
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUMW = SB + CW;
  localparam int SQW  = 2 * SB + CW;
  localparam int RST_SIZE = (DEF_WINDOW_SIZE > MAX_WINDOW) ? MAX_WINDOW : DEF_WINDOW_SIZE;
  localparam logic [PW:0]   MAXV = (PW+1)'(MAX_WINDOW);
  localparam logic [PW-1:0] LAST = PW'(MAX_WINDOW - 1);
  localparam logic [SB-1:0] SMAX = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EV_RD  = 4'd1;
  localparam logic [3:0] S_EV_SQ  = 4'd2;
  localparam logic [3:0] S_EV_SUB = 4'd3;
  localparam logic [3:0] S_ADD    = 4'd4;
  localparam logic [3:0] S_ADD_SQ = 4'd5;
  localparam logic [3:0] S_STAT   = 4'd6;
  localparam logic [3:0] S_RUN    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [SB-1:0] ring [MAX_WINDOW];
  logic [SB-1:0] rd_q_r;
  logic [PW-1:0] rd_addr;
  logic          we;

  logic [3:0]      state_r, state_nxt;
  logic [CW-1:0]   size_r, size_nxt;
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [SQW-1:0]  sumsq_r, sumsq_nxt;
  logic [SB-1:0]   cur_r, cur_nxt;
  logic            acc_r, acc_nxt;
  logic [2*SB-1:0] sq_r, sq_nxt;
  logic [PW-1:0]   scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic [CW-1:0]   cmp_r, cmp_nxt;
  logic            vld_r, vld_nxt;
  logic [SB-1:0]   min_r, min_nxt;
  logic [SB-1:0]   max_r, max_nxt;
  logic            calc_start;
  logic            calc_done;
  logic [SB-1:0]   calc_mean, calc_std;

  logic                out_valid_r, out_valid_nxt;
  logic                o_acc_r, o_has_r;
  logic [COUNT_W-1:0]  o_cnt_r;
  logic [SAMPLE_W-1:0] o_min_r, o_max_r, o_mean_r, o_std_r;
  logic                load;

  logic [PW:0]      old_sum;
  logic [PW-1:0]    oldest;
  logic [CFG_W-1:0] cfg_v;
  logic [CW-1:0]    cfg_size;
  logic             has;

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] a);
    ring_inc = (a == LAST) ? '0 : a + 1'b1;
  endfunction

  assign old_sum = {1'b0, wp_r} + MAXV - (PW+1)'(count_r);
  assign oldest  = (old_sum >= MAXV) ? PW'(old_sum - MAXV) : old_sum[PW-1:0];
  assign has     = (count_r != '0);

  assign cfg_chan.ready = 1'b1;
  assign cfg_v = cfg_chan.window_size;
  always_comb begin
    if (cfg_v == '0) begin
      cfg_size = CW'(1);
    end else if (32'(cfg_v) > MAX_WINDOW) begin
      cfg_size = CW'(MAX_WINDOW);
    end else begin
      cfg_size = CW'(cfg_v);
    end
  end

  rws_calc #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_calc (
    .clk  (clk),
    .rst_n(rst_n),
    .start(calc_start),
    .n    (count_r),
    .sum  (sum_r),
    .sumsq(sumsq_r),
    .done (calc_done),
    .mean (calc_mean),
    .std  (calc_std)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      ring[wp_r] <= cur_r;
    end
    rd_q_r <= ring[rd_addr];
  end

  assign load = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    scan_addr_nxt = scan_addr_r;
    iss_nxt       = iss_r;
    cmp_nxt       = cmp_r;
    vld_nxt       = vld_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cmd_ready     = 1'b0;
    calc_start    = 1'b0;
    we            = 1'b0;
    rd_addr       = scan_addr_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          acc_nxt   = 1'b0;
          state_nxt = S_STAT;
          case (cmd.kind)
            KIND_CLEAR: begin
              wp_nxt    = '0;
              count_nxt = '0;
              sum_nxt   = '0;
              sumsq_nxt = '0;
            end
            KIND_ADD: begin
              cur_nxt   = cmd.value[SB-1:0];
              acc_nxt   = 1'b1;
              state_nxt = (count_r >= size_r) ? S_EV_RD : S_ADD;
            end
            default: begin
            end
          endcase
        end
      end
      S_EV_RD: begin
        rd_addr   = oldest;
        state_nxt = S_EV_SQ;
      end
      S_EV_SQ: begin
        sq_nxt    = {{SB{1'b0}}, rd_q_r} * {{SB{1'b0}}, rd_q_r};
        sum_nxt   = sum_r - SUMW'(rd_q_r);
        state_nxt = S_EV_SUB;
      end
      S_EV_SUB: begin
        sumsq_nxt = sumsq_r - SQW'(sq_r);
        count_nxt = count_r - 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        we        = 1'b1;
        wp_nxt    = ring_inc(wp_r);
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_r + SUMW'(cur_r);
        sq_nxt    = {{SB{1'b0}}, cur_r} * {{SB{1'b0}}, cur_r};
        state_nxt = S_ADD_SQ;
      end
      S_ADD_SQ: begin
        sumsq_nxt = sumsq_r + SQW'(sq_r);
        state_nxt = S_STAT;
      end
      S_STAT: begin
        min_nxt = '0;
        max_nxt = '0;
        if (!has) begin
          state_nxt = S_EMIT;
        end else begin
          calc_start    = 1'b1;
          scan_addr_nxt = oldest;
          iss_nxt       = '0;
          cmp_nxt       = '0;
          vld_nxt       = 1'b0;
          min_nxt       = SMAX;
          state_nxt     = S_RUN;
        end
      end
      S_RUN: begin
        vld_nxt = 1'b0;
        if (iss_r < count_r) begin
          scan_addr_nxt = ring_inc(scan_addr_r);
          iss_nxt       = iss_r + 1'b1;
          vld_nxt       = 1'b1;
        end
        if (vld_r) begin
          cmp_nxt = cmp_r + 1'b1;
          if (rd_q_r < min_r) begin
            min_nxt = rd_q_r;
          end
          if (rd_q_r > max_r) begin
            max_nxt = rd_q_r;
          end
        end
        if ((cmp_r == count_r) && calc_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_chan.valid) begin
      size_nxt  = cfg_size;
      wp_nxt    = '0;
      count_nxt = '0;
      sum_nxt   = '0;
      sumsq_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    sq_r        <= sq_nxt;
    scan_addr_r <= scan_addr_nxt;
    iss_r       <= iss_nxt;
    cmp_r       <= cmp_nxt;
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    acc_r       <= acc_nxt;
    if (load) begin
      o_acc_r  <= acc_r;
      o_has_r  <= has;
      o_cnt_r  <= COUNT_W'(count_r);
      o_min_r  <= SAMPLE_W'(min_r);
      o_max_r  <= SAMPLE_W'(max_r);
      o_mean_r <= has ? SAMPLE_W'(calc_mean) : '0;
      o_std_r  <= has ? SAMPLE_W'(calc_std) : '0;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= CW'(RST_SIZE);
      wp_r        <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.accepted       = o_acc_r;
  assign out_chan.has_data       = o_has_r;
  assign out_chan.sample_count   = o_cnt_r;
  assign out_chan.window_min     = o_min_r;
  assign out_chan.window_max     = o_max_r;
  assign out_chan.window_mean    = o_mean_r;
  assign out_chan.window_std_dev = o_std_r;

endmodule

### hw/rtl/rolling_window_statistics.sv
// From an input transaction to result valid (receiver ready): a stored sample passes the
// add and add-square states, after the oldest sample is dropped (read, square, subtract)
// when the window is full; unless the window ends empty, the min/max scan then runs beside
// the bit-serial divider and square root in the calc unit. Throughput: one item at a time,
// the next starts the cycle after a result is loaded; a two-entry front queue and the
// result register let input and output stall independently. Reset (rst_n low, synchronous)
// empties the window and sets window_size to min(64, MAX_WINDOW); samples are not cleared.
module rolling_window_statistics import rws_pkg::*; #(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  rws_in_if.sink    in_chan,
  rws_out_if.source out_chan,
  rws_cfg_if.sink   cfg_chan
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  rws_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  rws_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

endmodule
